### rtl/jsu_pkg.sv
// shared types and constants for the json string unescaper
`default_nettype none
package jsu_pkg;

	localparam int MAX_RES = 6;
	localparam int CNT_W = 3;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} out_t;

	typedef struct packed {
		phase_t     phase;
		logic [11:0] hex_accum;
		logic [1:0] hex_count;
		logic [9:0] pending_high;
		logic       pending_valid;
	} state_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [MAX_RES-1:0][1:0] kinds;
		logic [CNT_W-1:0]        count;
	} res_list_t;

	localparam state_t STATE_CLEAR = '{
		phase: PH_IDLE,
		hex_accum: 12'd0,
		hex_count: 2'd0,
		pending_high: 10'd0,
		pending_valid: 1'b0
	};

endpackage
`default_nettype wire

### rtl/jsu_decode.sv
// next-state and result list logic for one input byte
`default_nettype none
module jsu_decode (
	input  wire jsu_pkg::in_t      item,
	input  wire jsu_pkg::state_t   cur,
	output jsu_pkg::state_t        nxt,
	output jsu_pkg::res_list_t     res
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} enc_t;

	function automatic enc_t encode_cp(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.b[0] = cp[7:0];
			e.n = 3'd1;
		end else if (cp < 21'h800) begin
			e.b[0] = {3'b110, cp[10:6]};
			e.b[1] = {2'b10, cp[5:0]};
			e.n = 3'd2;
		end else if (cp < 21'h10000) begin
			e.b[0] = {4'b1110, cp[15:12]};
			e.b[1] = {2'b10, cp[11:6]};
			e.b[2] = {2'b10, cp[5:0]};
			e.n = 3'd3;
		end else begin
			e.b[0] = {5'b11110, cp[20:18]};
			e.b[1] = {2'b10, cp[17:12]};
			e.b[2] = {2'b10, cp[11:6]};
			e.b[3] = {2'b10, cp[5:0]};
			e.n = 3'd4;
		end
		return e;
	endfunction

	logic [7:0]  b;
	logic        is_hex;
	logic [3:0]  digit;
	logic [15:0] v;
	logic        esc_ok;
	logic [7:0]  esc_val;
	logic        flush;
	logic        fail;
	enc_t        m;
	jsu_pkg::kind_t m_kind;
	logic [2:0][7:0] fl;

	assign b = item.in_byte;

	always_comb begin
		is_hex = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h66))
			|| ((b >= 8'h41) && (b <= 8'h46));
		digit = (b <= 8'h39) ? b[3:0] : b[3:0] + 4'd9;
		v = {cur.hex_accum, digit};
	end

	always_comb begin
		esc_ok = 1'b1;
		case (b)
			8'h22: esc_val = 8'h22;
			8'h5C: esc_val = 8'h5C;
			8'h2F: esc_val = 8'h2F;
			8'h62: esc_val = 8'h08;
			8'h66: esc_val = 8'h0C;
			8'h6E: esc_val = 8'h0A;
			8'h72: esc_val = 8'h0D;
			8'h74: esc_val = 8'h09;
			default: begin
				esc_val = 8'h00;
				esc_ok = 1'b0;
			end
		endcase
	end

	// held high surrogate as a three-byte sequence
	assign fl[0] = 8'hED;
	assign fl[1] = {4'b1010, cur.pending_high[9:6]};
	assign fl[2] = {2'b10, cur.pending_high[5:0]};

	always_comb begin
		nxt = cur;
		flush = 1'b0;
		fail = 1'b0;
		m = '0;
		m_kind = jsu_pkg::KIND_BYTE;
		case (cur.phase)
			jsu_pkg::PH_STR: begin
				if (item.text_end) begin
					fail = 1'b1;
				end else if (b == CH_QUOTE) begin
					flush = cur.pending_valid;
					nxt = jsu_pkg::STATE_CLEAR;
					m_kind = jsu_pkg::KIND_DONE;
					m.n = 3'd1;
				end else if (b == CH_BSLASH) begin
					nxt.phase = jsu_pkg::PH_ESC;
				end else begin
					flush = cur.pending_valid;
					nxt.pending_valid = 1'b0;
					nxt.pending_high = 10'd0;
					m.b[0] = b;
					m.n = 3'd1;
				end
			end
			jsu_pkg::PH_ESC: begin
				if (item.text_end) begin
					fail = 1'b1;
				end else if (b == CH_U) begin
					nxt.phase = jsu_pkg::PH_HEX;
					nxt.hex_accum = 12'd0;
					nxt.hex_count = 2'd0;
				end else if (esc_ok) begin
					flush = cur.pending_valid;
					nxt.pending_valid = 1'b0;
					nxt.pending_high = 10'd0;
					nxt.phase = jsu_pkg::PH_STR;
					m.b[0] = esc_val;
					m.n = 3'd1;
				end else begin
					fail = 1'b1;
				end
			end
			jsu_pkg::PH_HEX: begin
				if (item.text_end || !is_hex) begin
					fail = 1'b1;
				end else if (cur.hex_count != 2'd3) begin
					nxt.hex_accum = v[11:0];
					nxt.hex_count = cur.hex_count + 2'd1;
				end else begin
					nxt.phase = jsu_pkg::PH_STR;
					nxt.hex_accum = 12'd0;
					nxt.hex_count = 2'd0;
					nxt.pending_valid = 1'b0;
					nxt.pending_high = 10'd0;
					if (cur.pending_valid && (v >= 16'hDC00) && (v <= 16'hDFFF)) begin
						m = encode_cp(21'h10000 + {1'b0, cur.pending_high, v[9:0]});
					end else begin
						flush = cur.pending_valid;
						if ((v >= 16'hD800) && (v <= 16'hDBFF)) begin
							nxt.pending_high = v[9:0];
							nxt.pending_valid = 1'b1;
						end else begin
							m = encode_cp({5'd0, v});
						end
					end
				end
			end
			default: begin
				if (item.text_end || (b != CH_QUOTE)) begin
					fail = 1'b1;
				end else begin
					nxt = jsu_pkg::STATE_CLEAR;
					nxt.phase = jsu_pkg::PH_STR;
				end
			end
		endcase
		if (fail) begin
			nxt = jsu_pkg::STATE_CLEAR;
			flush = 1'b0;
			m = '0;
			m.n = 3'd1;
			m_kind = jsu_pkg::KIND_ERR;
		end
	end

	always_comb begin
		res = '0;
		if (flush) begin
			res.bytes[0] = fl[0];
			res.bytes[1] = fl[1];
			res.bytes[2] = fl[2];
			res.kinds[0] = jsu_pkg::KIND_BYTE;
			res.kinds[1] = jsu_pkg::KIND_BYTE;
			res.kinds[2] = jsu_pkg::KIND_BYTE;
			res.bytes[3] = m.b[0];
			res.bytes[4] = m.b[1];
			res.bytes[5] = m.b[2];
			res.kinds[3] = m_kind;
			res.kinds[4] = m_kind;
			res.kinds[5] = m_kind;
			res.count = m.n + 3'd3;
		end else begin
			res.bytes[0] = m.b[0];
			res.bytes[1] = m.b[1];
			res.bytes[2] = m.b[2];
			res.bytes[3] = m.b[3];
			res.kinds[0] = m_kind;
			res.kinds[1] = m_kind;
			res.kinds[2] = m_kind;
			res.kinds[3] = m_kind;
			res.count = m.n;
		end
	end

endmodule
`default_nettype wire

### rtl/jsu_outbuf.sv
// result register that hands out the result list one transaction at a time
`default_nettype none
module jsu_outbuf (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      load,
	input  wire jsu_pkg::res_list_t  res,
	output logic                     load_ok,
	output logic                     dec_valid,
	input  wire                      dec_ready,
	output jsu_pkg::out_t            dec_data
);

	jsu_pkg::res_list_t           list_q;
	logic [jsu_pkg::CNT_W-1:0]    count_q;
	logic [jsu_pkg::CNT_W-1:0]    idx_q;
	logic [jsu_pkg::CNT_W-1:0]    idx_inc;

	assign idx_inc = idx_q + jsu_pkg::CNT_W'(1);
	assign dec_valid = (idx_q != count_q);
	assign load_ok = (idx_q == count_q) || ((idx_inc == count_q) && dec_ready);

	always_comb begin
		dec_data = '0;
		if (dec_valid) begin
			dec_data.out_byte = list_q.bytes[idx_q];
			dec_data.kind = list_q.kinds[idx_q];
			dec_data.last = (idx_inc == count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			count_q <= res.count;
			idx_q <= '0;
		end else if (dec_valid && dec_ready) begin
			idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= res;
		end
	end

endmodule
`default_nettype wire

### rtl/json_string_unescape_utf8_core.sv
// top level of the json string unescaper with utf-8 output
// the first result of a transaction appears in the cycle after it is accepted
// throughput: one input transaction per cycle while each yields at most one result and
// dec_ready is high; an input yielding more results (up to six) holds the input side
// until the single result register drains them, one per cycle while dec_ready is high
// reset: arst_n clears to idle awaiting an opening quote with no results pending
`default_nettype none
module json_string_unescape_utf8_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 text_valid,
	output logic                text_ready,
	input  wire jsu_pkg::in_t   text_data,
	output logic                dec_valid,
	input  wire                 dec_ready,
	output jsu_pkg::out_t       dec_data
);

	jsu_pkg::state_t    state_q;
	jsu_pkg::state_t    state_nxt;
	jsu_pkg::res_list_t res;
	logic               load_ok;
	logic               fire;

	assign text_ready = load_ok;
	assign fire = text_valid && load_ok;

	jsu_decode u_decode (
		.item (text_data),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	jsu_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res       (res),
		.load_ok   (load_ok),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec_data  (dec_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsu_pkg::STATE_CLEAR;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

### tb/json_string_unescape_utf8_core_test.sv
// testbench for the json string unescaper: directed and random strings checked against a predictor
`timescale 1ns / 100ps
module json_string_unescape_utf8_core_test;

	localparam logic [7:0] CH_QUOTE = "\"";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_U = "u";
	localparam int STRING_ITEMS = 450;
	localparam int QUIET_TAIL = 60;
	localparam int HOLD_START = 120;
	localparam int HOLD_CYCLES = 300;

	class unescape_scoreboard;
		jsu_pkg::phase_t ph;
		logic [15:0] acc;
		int unsigned ndig;
		logic [9:0]  held;
		bit          held_v;
		jsu_pkg::out_t expected_q[$];
		jsu_pkg::out_t item_q[$];
		int          fails;

		function void clear_state();
			ph = jsu_pkg::PH_IDLE;
			acc = '0;
			ndig = 0;
			held = '0;
			held_v = 1'b0;
		endfunction

		function void emit(logic [7:0] b, jsu_pkg::kind_t k);
			jsu_pkg::out_t r;
			r.out_byte = b;
			r.kind = k;
			r.last = 1'b0;
			item_q = {item_q, r};
		endfunction

		// utf-8 encoding of one code point
		function void emit_cp(int unsigned cp);
			if (cp < 'h80) begin
				emit(8'(cp), jsu_pkg::KIND_BYTE);
			end else if (cp < 'h800) begin
				emit(8'('hC0 | (cp >> 6)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_BYTE);
			end else if (cp < 'h10000) begin
				emit(8'('hE0 | (cp >> 12)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | ((cp >> 6) & 'h3F)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_BYTE);
			end else begin
				emit(8'('hF0 | (cp >> 18)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | ((cp >> 12) & 'h3F)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | ((cp >> 6) & 'h3F)), jsu_pkg::KIND_BYTE);
				emit(8'('h80 | (cp & 'h3F)), jsu_pkg::KIND_BYTE);
			end
		endfunction

		function void flush_held();
			if (held_v) begin
				emit_cp('hD800 + held);
				held_v = 1'b0;
				held = '0;
			end
		endfunction

		function void fail_item();
			clear_state();
			emit(8'h00, jsu_pkg::KIND_ERR);
		endfunction

		function int hex_digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return int'(c - "0");
			if (c >= "a" && c <= "f")
				return int'(c - "a") + 10;
			if (c >= "A" && c <= "F")
				return int'(c - "A") + 10;
			return -1;
		endfunction

		function int escape_char(logic [7:0] c);
			case (c)
				"\"": return 'h22;
				"\\": return 'h5C;
				"/": return 'h2F;
				"b": return 'h08;
				"f": return 'h0C;
				"n": return 'h0A;
				"r": return 'h0D;
				"t": return 'h09;
				default: return -1;
			endcase
		endfunction

		function void note_input(jsu_pkg::in_t it);
			int d;
			int e;
			int unsigned v;
			logic [7:0] b;
			b = it.in_byte;
			item_q.delete();
			if (ph == jsu_pkg::PH_IDLE) begin
				if (it.text_end || b != CH_QUOTE) begin
					fail_item();
				end else begin
					clear_state();
					ph = jsu_pkg::PH_STR;
				end
			end else if (it.text_end) begin
				fail_item();
			end else if (ph == jsu_pkg::PH_STR) begin
				if (b == CH_QUOTE) begin
					flush_held();
					clear_state();
					emit(8'h00, jsu_pkg::KIND_DONE);
				end else if (b == CH_BSLASH) begin
					ph = jsu_pkg::PH_ESC;
				end else begin
					flush_held();
					emit(b, jsu_pkg::KIND_BYTE);
				end
			end else if (ph == jsu_pkg::PH_ESC) begin
				if (b == CH_U) begin
					ph = jsu_pkg::PH_HEX;
					acc = '0;
					ndig = 0;
				end else begin
					e = escape_char(b);
					if (e < 0) begin
						fail_item();
					end else begin
						flush_held();
						emit(8'(e), jsu_pkg::KIND_BYTE);
						ph = jsu_pkg::PH_STR;
					end
				end
			end else begin
				d = hex_digit_value(b);
				if (d < 0) begin
					fail_item();
				end else begin
					acc = {acc[11:0], d[3:0]};
					ndig++;
					if (ndig >= 4) begin
						v = acc;
						ph = jsu_pkg::PH_STR;
						acc = '0;
						ndig = 0;
						if (held_v && v >= 'hDC00 && v <= 'hDFFF) begin
							emit_cp('h10000 + (int'(held) << 10) + (v - 'hDC00));
							held_v = 1'b0;
							held = '0;
						end else begin
							flush_held();
							if (v >= 'hD800 && v <= 'hDBFF) begin
								held = 10'(v - 'hD800);
								held_v = 1'b1;
							end else begin
								emit_cp(v);
							end
						end
					end
				end
			end
			if (item_q.size() > 0)
				item_q[item_q.size() - 1].last = 1'b1;
			foreach (item_q[i])
				expected_q = {expected_q, item_q[i]};
		endfunction

		function void check_result(jsu_pkg::out_t got);
			jsu_pkg::out_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual byte %h kind %0d last %0d",
					$time, got.out_byte, got.kind, got.last);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
				got.last !== want.last) begin
				$display({"%0t: mismatch, expected byte %h kind %0d last %0d, ",
					"actual byte %h kind %0d last %0d"},
					$time, want.out_byte, want.kind, want.last,
					got.out_byte, got.kind, got.last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic text_valid;
	logic text_ready;
	jsu_pkg::in_t  text_data;
	logic dec_valid;
	logic dec_ready;
	jsu_pkg::out_t dec_data;
	logic hold_off;
	int   sent = 0;
	jsu_pkg::in_t  stim_q[$];
	unescape_scoreboard sb;
	logic [7:0] esc_letters [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

	json_string_unescape_utf8_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_data(text_data),
		.dec_valid(dec_valid),
		.dec_ready(dec_ready),
		.dec_data(dec_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit quiet_phase();
		return sent + QUIET_TAIL >= stim_q.size();
	endfunction

	task automatic push_byte(logic [7:0] b);
		jsu_pkg::in_t it;
		it.in_byte = b;
		it.text_end = 1'b0;
		stim_q = {stim_q, it};
	endtask

	task automatic push_end();
		jsu_pkg::in_t it;
		it.in_byte = 8'($urandom_range(0, 255));
		it.text_end = 1'b1;
		stim_q = {stim_q, it};
	endtask

	function automatic logic [7:0] hex_char(int d);
		if (d < 10)
			return 8'("0" + d);
		if ($urandom_range(0, 1))
			return 8'("a" + d - 10);
		return 8'("A" + d - 10);
	endfunction

	task automatic push_uescape(logic [15:0] v);
		push_byte(CH_BSLASH);
		push_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			push_byte(hex_char(int'(v[i*4 +: 4])));
	endtask

	task automatic push_raw();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_QUOTE || b == CH_BSLASH);
		push_byte(b);
	endtask

	task automatic gen_string();
		int ntok;
		int sel;
		logic [7:0] b;
		push_byte(CH_QUOTE);
		ntok = $urandom_range(0, 6);
		repeat (ntok) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1, 2: push_raw();
				3, 4: begin
					push_byte(CH_BSLASH);
					push_byte(esc_letters[$urandom_range(0, 7)]);
				end
				5: push_uescape(16'($urandom_range(0, 'hFFFF)));
				6: push_uescape(16'($urandom_range(0, 'h7FF)));
				7: push_uescape(16'($urandom_range('hD800, 'hDBFF)));
				8: begin
					push_uescape(16'($urandom_range('hD800, 'hDBFF)));
					push_uescape(16'($urandom_range('hDC00, 'hDFFF)));
				end
				default: push_uescape(16'($urandom_range('hDC00, 'hDFFF)));
			endcase
		end
		sel = $urandom_range(0, 19);
		case (sel)
			0: push_end();
			1: begin
				push_byte(CH_BSLASH);
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_U || sb.escape_char(b) >= 0);
				push_byte(b);
			end
			2: begin
				push_byte(CH_BSLASH);
				push_byte(CH_U);
				repeat ($urandom_range(0, 3))
					push_byte(hex_char($urandom_range(0, 15)));
				do
					b = 8'($urandom_range(0, 255));
				while (sb.hex_digit_value(b) >= 0);
				push_byte(b);
			end
			3: begin
				push_byte(CH_QUOTE);
				repeat ($urandom_range(1, 2)) begin
					if ($urandom_range(0, 3) == 0)
						push_end();
					else
						push_raw();
				end
			end
			default: push_byte(CH_QUOTE);
		endcase
	endtask

	task automatic build_stimulus();
		// stray byte and end of text while idle
		push_byte("x");
		push_end();
		push_byte(CH_QUOTE);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_BSLASH);
		push_byte("/");
		// held high surrogate then its low half
		push_uescape(16'hDBFF);
		push_byte(CH_BSLASH);
		push_byte(CH_U);
		push_byte("d");
		push_byte("c");
		push_byte("0");
		push_byte("0");
		// held high surrogate flushed by the closing quote
		push_uescape(16'hD800);
		push_byte(CH_QUOTE);
		// unknown escape letter
		push_byte(CH_QUOTE);
		push_byte(CH_BSLASH);
		push_byte("q");
		while (stim_q.size() < STRING_ITEMS)
			gen_string();
	endtask

	task automatic drive_all();
		int gap;
		for (int i = 0; i < stim_q.size(); i++) begin
			text_data <= stim_q[i];
			text_valid <= 1'b1;
			do
				@(posedge clk);
			while (!text_ready);
			sb.note_input(stim_q[i]);
			sent = i + 1;
			if (!quiet_phase() && $urandom_range(0, 3) == 0) begin
				text_valid <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(posedge clk);
			end
		end
		text_valid <= 1'b0;
	endtask

	task automatic drain_results();
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (dec_valid && dec_ready)
				sb.check_result(dec_data);
			if (stall > 0)
				stall--;
			else if (!quiet_phase() && $urandom_range(0, 4) == 0)
				stall = $urandom_range(1, 6);
			dec_ready <= (stall == 0) && !hold_off;
		end
	endtask

	// long receiver stall so the block backs up into its input
	task automatic hold_off_once();
		wait (sent >= HOLD_START);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		text_valid <= 1'b0;
		text_data <= '0;
		dec_ready <= 1'b0;
		hold_off <= 1'b0;
		sb = new;
		sb.clear_state();
		sb.fails = 0;
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_results();
			hold_off_once();
		join_none
		drive_all();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
